[rtl/tcet_pkg.sv]
`timescale 1ns / 1ps
// Package for the text console escape terminal: screen geometry, widths, character codes,
// controller states and the command/status structs between controller and datapath.
// Depends on nothing.
package tcet_pkg;

  localparam int SCREEN_ROWS = 25;
  localparam int SCREEN_COLS = 80;
  localparam int TAB_WIDTH   = 8;

  localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLS;
  localparam int LAST_LINE  = (SCREEN_ROWS - 1) * SCREEN_COLS;

  localparam int POS_W  = $clog2(CELL_COUNT);
  localparam int COL_W  = $clog2(SCREEN_COLS);
  localparam int TPH_W  = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int IDX_W  = 11;
  localparam int CHAR_W = 7;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;
  localparam int ARG_W  = 12;
  localparam int DIG_W  = 4;

  localparam logic [ARG_W-1:0]  ARG_MAX    = {ARG_W{1'b1}};
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CH_TILDE = 7'h7E;
  localparam logic [CHAR_W-1:0] CH_NL    = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 7'h0D;
  localparam logic [CHAR_W-1:0] CH_BS    = 7'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 7'h09;
  localparam logic [CHAR_W-1:0] CH_ESC   = 7'h1B;
  localparam logic [CHAR_W-1:0] CH_LBR   = 7'h5B;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 7'h3B;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;
  localparam logic [CHAR_W-1:0] CH_UP_H  = 7'h48;
  localparam logic [CHAR_W-1:0] CH_UP_J  = 7'h4A;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_READ_WAIT,
    S_POS,
    S_DIV_COL,
    S_DIV_TAB,
    S_SCR_PRIME,
    S_SCR_MOVE,
    S_FILL,
    S_FINISH
  } ctrl_state_e;

  typedef enum logic [2:0] {
    ESC_IDLE,
    ESC_SEEN,
    ESC_BRACKET,
    ESC_ROW,
    ESC_COL
  } esc_e;

  typedef enum logic [1:0] {
    POS_HOME,
    POS_ROW,
    POS_FULL
  } pos_sel_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_READ,
    OP_CAPTURE,
    OP_PRINT,
    OP_NL,
    OP_CR,
    OP_BS,
    OP_TAB,
    OP_ROW_FIRST,
    OP_ROW_DIGIT,
    OP_COL_ZERO,
    OP_COL_DIGIT,
    OP_HOME,
    OP_POS_START,
    OP_POS_SET,
    OP_DIV_COL,
    OP_DIV_TAB,
    OP_SCR_READ,
    OP_SCR_MOVE,
    OP_FILL,
    OP_INIT_FILL,
    OP_DONE
  } dp_op_e;

  typedef struct packed {
    dp_op_e   op;
    pos_sel_e pos_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic is_digit;
    logic is_print;
    logic is_nl;
    logic is_cr;
    logic is_bs;
    logic is_tab;
    logic is_esc;
    logic is_lbr;
    logic is_semi;
    logic is_h;
    logic is_j;
    logic idx_ok;
    logic print_wrap;
    logic nl_scroll;
    logic tab_scroll;
    logic move_last;
    logic fill_last;
    logic lt_cols;
    logic lt_tab;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/text_console_escape_terminal.sv]
`timescale 1ns / 1ps
// Top level of the text console escape terminal: joins controller and datapath.
// Depends on tcet_pkg, tcet_ctrl and tcet_dp.
//
//   channel  dir  handshake                payload
//   in       in   in_valid_i / in_ready_o    mode_i, char_code_i, end_of_string_i, read_index_i
//   out      out  out_valid_o / out_ready_i  cursor_index_o, cell_char_o, cell_attr_o
//   cfg      in   cfg_valid_i / cfg_ready_o  normal_attr_i
//
// A printable byte, newline or carriage return that does not scroll passes accept, decode, result.
// A cell read adds a capture step after decode, for the registered read port of the screen store.
// Backspace, a tab that does not scroll and cursor positioning add the subtract-per-cycle column
// derivation; scroll and clear walk the store through its single write port.
// After reset a clearing pass over all CELL_COUNT cells runs with in_ready_o low; cfg writes
// are taken at all times. A new request is taken while a result waits for out_ready_i.
module text_console_escape_terminal (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [7:0]                    char_code_i,
  input  logic                          end_of_string_i,
  input  logic [tcet_pkg::IDX_W-1:0]    read_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tcet_pkg::IDX_W-1:0]    cursor_index_o,
  output logic [tcet_pkg::CHAR_W-1:0]   cell_char_o,
  output logic [tcet_pkg::ATTR_W-1:0]   cell_attr_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tcet_pkg::ATTR_W-1:0]   normal_attr_i
);

  tcet_pkg::dp_cmd_t    cmd;
  tcet_pkg::dp_status_t status;
  logic                 cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  tcet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcet_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .mode_i          (mode_i),
    .char_code_i     (char_code_i),
    .end_of_string_i (end_of_string_i),
    .read_index_i    (read_index_i),
    .cfg_we_i        (cfg_we),
    .normal_attr_i   (normal_attr_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .cursor_index_o  (cursor_index_o),
    .cell_char_o     (cell_char_o),
    .cell_attr_o     (cell_attr_o)
  );

endmodule

[rtl/tcet_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the text console escape terminal: request sequencing state machine and
// escape sequence phase. Depends on tcet_pkg; drives tcet_dp through dp_cmd_t.
module tcet_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tcet_pkg::dp_status_t  status_i,
  output tcet_pkg::dp_cmd_t     cmd_o
);

  tcet_pkg::ctrl_state_e state_q, state_d;
  tcet_pkg::esc_e        esc_q, esc_d;

  tcet_pkg::dp_op_e      act_op;
  tcet_pkg::ctrl_state_e act_state;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcet_pkg::S_INIT;
      esc_q   <= tcet_pkg::ESC_IDLE;
    end else begin
      state_q <= state_d;
      esc_q   <= esc_d;
    end
  end

  // final byte of an escape sequence
  always_comb begin
    if (status_i.is_j) begin
      act_op    = tcet_pkg::OP_HOME;
      act_state = tcet_pkg::S_FILL;
    end else if (status_i.is_h) begin
      act_op    = tcet_pkg::OP_POS_START;
      act_state = tcet_pkg::S_POS;
    end else begin
      act_op    = tcet_pkg::OP_NONE;
      act_state = tcet_pkg::S_FINISH;
    end
  end

  always_comb begin
    state_d       = state_q;
    esc_d         = esc_q;
    in_ready_o    = 1'b0;
    cmd_o.op      = tcet_pkg::OP_NONE;
    cmd_o.pos_sel = tcet_pkg::POS_HOME;

    case (state_q)
      tcet_pkg::S_INIT: begin
        cmd_o.op = tcet_pkg::OP_INIT_FILL;
        if (status_i.fill_last) begin
          state_d = tcet_pkg::S_IDLE;
        end
      end

      tcet_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = tcet_pkg::OP_LATCH;
          state_d  = tcet_pkg::S_DECODE;
        end
      end

      tcet_pkg::S_DECODE: begin
        state_d = tcet_pkg::S_FINISH;
        if (status_i.mode) begin
          if (status_i.idx_ok) begin
            cmd_o.op = tcet_pkg::OP_READ;
            state_d  = tcet_pkg::S_READ_WAIT;
          end
        end else begin
          case (esc_q)
            tcet_pkg::ESC_IDLE: begin
              if (status_i.is_print) begin
                cmd_o.op = tcet_pkg::OP_PRINT;
                if (status_i.print_wrap) begin
                  state_d = tcet_pkg::S_SCR_PRIME;
                end
              end else if (status_i.is_nl) begin
                cmd_o.op = tcet_pkg::OP_NL;
                if (status_i.nl_scroll) begin
                  state_d = tcet_pkg::S_SCR_PRIME;
                end
              end else if (status_i.is_cr) begin
                cmd_o.op = tcet_pkg::OP_CR;
              end else if (status_i.is_bs) begin
                cmd_o.op = tcet_pkg::OP_BS;
                state_d  = tcet_pkg::S_DIV_COL;
              end else if (status_i.is_tab) begin
                cmd_o.op = tcet_pkg::OP_TAB;
                state_d  = status_i.tab_scroll ? tcet_pkg::S_SCR_PRIME : tcet_pkg::S_DIV_COL;
              end else if (status_i.is_esc) begin
                esc_d = tcet_pkg::ESC_SEEN;
              end
            end
            tcet_pkg::ESC_SEEN: begin
              esc_d = status_i.is_lbr ? tcet_pkg::ESC_BRACKET : tcet_pkg::ESC_IDLE;
            end
            tcet_pkg::ESC_BRACKET: begin
              if (status_i.is_digit) begin
                cmd_o.op = tcet_pkg::OP_ROW_FIRST;
                esc_d    = tcet_pkg::ESC_ROW;
              end else begin
                cmd_o.op      = act_op;
                cmd_o.pos_sel = tcet_pkg::POS_HOME;
                state_d       = act_state;
                esc_d         = tcet_pkg::ESC_IDLE;
              end
            end
            tcet_pkg::ESC_ROW: begin
              if (status_i.is_digit) begin
                cmd_o.op = tcet_pkg::OP_ROW_DIGIT;
              end else if (status_i.is_semi) begin
                cmd_o.op = tcet_pkg::OP_COL_ZERO;
                esc_d    = tcet_pkg::ESC_COL;
              end else begin
                cmd_o.op      = act_op;
                cmd_o.pos_sel = tcet_pkg::POS_ROW;
                state_d       = act_state;
                esc_d         = tcet_pkg::ESC_IDLE;
              end
            end
            tcet_pkg::ESC_COL: begin
              if (status_i.is_digit) begin
                cmd_o.op = tcet_pkg::OP_COL_DIGIT;
              end else begin
                cmd_o.op      = act_op;
                cmd_o.pos_sel = tcet_pkg::POS_FULL;
                state_d       = act_state;
                esc_d         = tcet_pkg::ESC_IDLE;
              end
            end
            default: begin
              esc_d = tcet_pkg::ESC_IDLE;
            end
          endcase
        end
      end

      tcet_pkg::S_READ_WAIT: begin
        cmd_o.op = tcet_pkg::OP_CAPTURE;
        state_d  = tcet_pkg::S_FINISH;
      end

      tcet_pkg::S_POS: begin
        cmd_o.op = tcet_pkg::OP_POS_SET;
        state_d  = tcet_pkg::S_DIV_COL;
      end

      tcet_pkg::S_DIV_COL: begin
        cmd_o.op = tcet_pkg::OP_DIV_COL;
        if (status_i.lt_cols) begin
          state_d = tcet_pkg::S_DIV_TAB;
        end
      end

      tcet_pkg::S_DIV_TAB: begin
        cmd_o.op = tcet_pkg::OP_DIV_TAB;
        if (status_i.lt_tab) begin
          state_d = tcet_pkg::S_FINISH;
        end
      end

      tcet_pkg::S_SCR_PRIME: begin
        cmd_o.op = tcet_pkg::OP_SCR_READ;
        state_d  = tcet_pkg::S_SCR_MOVE;
      end

      tcet_pkg::S_SCR_MOVE: begin
        cmd_o.op = tcet_pkg::OP_SCR_MOVE;
        if (status_i.move_last) begin
          state_d = tcet_pkg::S_FILL;
        end
      end

      tcet_pkg::S_FILL: begin
        cmd_o.op = tcet_pkg::OP_FILL;
        if (status_i.fill_last) begin
          state_d = tcet_pkg::S_FINISH;
        end
      end

      tcet_pkg::S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.op = tcet_pkg::OP_DONE;
          state_d  = tcet_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = tcet_pkg::S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == tcet_pkg::S_DECODE)
    else $error("accepted request did not enter decode");

  a_esc_only_in_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(esc_q) |-> $past(state_q) == tcet_pkg::S_DECODE)
    else $error("escape phase changed outside decode");

  a_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tcet_pkg::S_FINISH && !status_i.out_free |=> state_q == tcet_pkg::S_FINISH)
    else $error("finish left while result register busy");
`endif

endmodule

[rtl/tcet_dp.sv]
`timescale 1ns / 1ps
// Datapath of the text console escape terminal: screen store, write position, escape
// arguments, column divider, sweep counter and result register. Depends on tcet_pkg.
module tcet_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tcet_pkg::dp_cmd_t                    cmd_i,
  output tcet_pkg::dp_status_t                 status_o,
  input  logic                                 mode_i,
  input  logic [7:0]                           char_code_i,
  input  logic                                 end_of_string_i,
  input  logic [tcet_pkg::IDX_W-1:0]           read_index_i,
  input  logic                                 cfg_we_i,
  input  logic [tcet_pkg::ATTR_W-1:0]          normal_attr_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [tcet_pkg::IDX_W-1:0]           cursor_index_o,
  output logic [tcet_pkg::CHAR_W-1:0]          cell_char_o,
  output logic [tcet_pkg::ATTR_W-1:0]          cell_attr_o
);

  localparam int PosW    = tcet_pkg::POS_W;
  localparam int ColW    = tcet_pkg::COL_W;
  localparam int TphW    = tcet_pkg::TPH_W;
  localparam int IdxW    = tcet_pkg::IDX_W;
  localparam int CharW   = tcet_pkg::CHAR_W;
  localparam int AttrW   = tcet_pkg::ATTR_W;
  localparam int CellW   = tcet_pkg::CELL_W;
  localparam int ArgW    = tcet_pkg::ARG_W;
  localparam int DigW    = tcet_pkg::DIG_W;
  localparam int CellCnt = tcet_pkg::CELL_COUNT;
  localparam int LastLn  = tcet_pkg::LAST_LINE;
  localparam int Cols    = tcet_pkg::SCREEN_COLS;
  localparam int TabW    = tcet_pkg::TAB_WIDTH;
  localparam int ProdW   = ArgW + ColW + 3;
  localparam int SumW    = ProdW + 1;
  localparam int CmpW    = ((PosW > IdxW) ? PosW : IdxW) + 1;

  function automatic logic [ArgW-1:0] add_digit(input logic [ArgW-1:0] v,
                                                 input logic [DigW-1:0] d);
    logic [ArgW+3:0] n;
    n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{ArgW{1'b0}}, d};
    return (n > (ArgW+4)'(tcet_pkg::ARG_MAX)) ? tcet_pkg::ARG_MAX : n[ArgW-1:0];
  endfunction

  // control state
  logic [PosW-1:0]  lin_q, lin_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [TphW-1:0]  tph_q, tph_d;
  logic [PosW-1:0]  shown_q, shown_d;
  logic [ArgW-1:0]  arg_row_q, arg_row_d;
  logic [ArgW-1:0]  arg_col_q, arg_col_d;
  logic [AttrW-1:0] attr_q;
  logic [PosW-1:0]  sw_q, sw_d;
  logic             out_valid_q, out_valid_d;

  // payload
  logic               mode_q;
  logic [CharW-1:0]   char_q;
  logic               eos_q;
  logic [IdxW-1:0]    idx_q;
  logic [CellW-1:0]   cell_q;
  logic [CellW-1:0]   rd_q;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic [ArgW-1:0]    ecol_q, ecol_d;
  logic [PosW-1:0]    div_q, div_d;
  logic [IdxW-1:0]    out_cursor_q;
  logic [CellW-1:0]   out_cell_q;

  logic [CellW-1:0]   scr_mem [CellCnt];
  logic               mem_we, mem_re;
  logic [PosW-1:0]    mem_waddr, mem_raddr;
  logic [CellW-1:0]   mem_wdata;

  logic [PosW:0]      lin_inc, lin_nl, lin_tab;
  logic [DigW-1:0]    dig;
  logic [ArgW-1:0]    pos_row, pos_col;
  logic signed [ArgW:0]   row_m1;
  logic signed [ColW+1:0] cols_s;
  logic [SumW-1:0]    tgt;
  logic               tgt_neg, tgt_big;
  logic [PosW-1:0]    tgt_pos;
  logic               col_wrap;

  assign dig     = char_q[DigW-1:0];
  assign lin_inc = {1'b0, lin_q} + (PosW+1)'(1);
  assign lin_nl  = {1'b0, lin_q} + (PosW+1)'(Cols);
  assign lin_tab = {1'b0, lin_q} + (PosW+1)'(TabW) - (PosW+1)'(tph_q);
  assign col_wrap = (col_q == ColW'(Cols - 1));

  always_comb begin
    case (cmd_i.pos_sel)
      tcet_pkg::POS_ROW: begin
        pos_row = arg_row_q;
        pos_col = ArgW'(1);
      end
      tcet_pkg::POS_FULL: begin
        pos_row = arg_row_q;
        pos_col = arg_col_q;
      end
      default: begin
        pos_row = ArgW'(1);
        pos_col = ArgW'(1);
      end
    endcase
  end

  assign row_m1  = $signed({1'b0, pos_row} - {{ArgW{1'b0}}, 1'b1});
  assign cols_s  = $signed((ColW+2)'(Cols));
  assign prod_d  = row_m1 * cols_s;
  assign tgt     = {prod_q[ProdW-1], prod_q} + {{(SumW-ArgW){1'b0}}, ecol_q} - SumW'(1);
  assign tgt_neg = tgt[SumW-1];
  assign tgt_big = !tgt_neg && (tgt >= SumW'(CellCnt));
  assign tgt_pos = tgt_neg ? '0 : (tgt_big ? PosW'(LastLn) : PosW'(tgt));

  always_comb begin
    status_o.mode       = mode_q;
    status_o.is_digit   = char_q inside {[tcet_pkg::CH_ZERO:tcet_pkg::CH_NINE]};
    status_o.is_print   = char_q inside {[tcet_pkg::CH_SPACE:tcet_pkg::CH_TILDE]};
    status_o.is_nl      = (char_q == tcet_pkg::CH_NL);
    status_o.is_cr      = (char_q == tcet_pkg::CH_CR);
    status_o.is_bs      = (char_q == tcet_pkg::CH_BS);
    status_o.is_tab     = (char_q == tcet_pkg::CH_TAB);
    status_o.is_esc     = (char_q == tcet_pkg::CH_ESC);
    status_o.is_lbr     = (char_q == tcet_pkg::CH_LBR);
    status_o.is_semi    = (char_q == tcet_pkg::CH_SEMI);
    status_o.is_h       = (char_q == tcet_pkg::CH_UP_H);
    status_o.is_j       = (char_q == tcet_pkg::CH_UP_J);
    status_o.idx_ok     = CmpW'(idx_q) < CmpW'(CellCnt);
    status_o.print_wrap = lin_inc >= (PosW+1)'(CellCnt);
    status_o.nl_scroll  = lin_nl >= (PosW+1)'(CellCnt);
    status_o.tab_scroll = lin_tab >= (PosW+1)'(CellCnt);
    status_o.move_last  = (sw_q == PosW'(LastLn - 1));
    status_o.fill_last  = (sw_q == PosW'(CellCnt - 1));
    status_o.lt_cols    = div_q < PosW'(Cols);
    status_o.lt_tab     = div_q < PosW'(TabW);
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    lin_d       = lin_q;
    col_d       = col_q;
    tph_d       = tph_q;
    shown_d     = shown_q;
    arg_row_d   = arg_row_q;
    arg_col_d   = arg_col_q;
    sw_d        = '0;
    div_d       = div_q;
    ecol_d      = ecol_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = sw_q;
    mem_raddr   = sw_q + PosW'(Cols);
    mem_wdata   = {attr_q, tcet_pkg::CH_SPACE};

    case (cmd_i.op)
      tcet_pkg::OP_READ: begin
        mem_re    = 1'b1;
        mem_raddr = PosW'(idx_q);
      end
      tcet_pkg::OP_PRINT: begin
        mem_we    = 1'b1;
        mem_waddr = lin_q;
        mem_wdata = {attr_q, char_q};
        lin_d     = status_o.print_wrap ? PosW'(LastLn) : PosW'(lin_inc);
        col_d     = col_wrap ? '0 : col_q + ColW'(1);
        tph_d     = (col_wrap || tph_q == TphW'(TabW - 1)) ? '0 : tph_q + TphW'(1);
      end
      tcet_pkg::OP_NL: begin
        lin_d = status_o.nl_scroll ? PosW'(LastLn) : PosW'(lin_nl - (PosW+1)'(col_q));
        col_d = '0;
        tph_d = '0;
      end
      tcet_pkg::OP_CR: begin
        lin_d = lin_q - PosW'(col_q);
        col_d = '0;
        tph_d = '0;
      end
      tcet_pkg::OP_BS: begin
        lin_d = (lin_q != '0) ? lin_q - PosW'(1) : lin_q;
        div_d = lin_d;
      end
      tcet_pkg::OP_TAB: begin
        if (status_o.tab_scroll) begin
          lin_d = PosW'(LastLn);
          col_d = '0;
          tph_d = '0;
        end else begin
          lin_d = PosW'(lin_tab);
        end
        div_d = lin_d;
      end
      tcet_pkg::OP_ROW_FIRST: begin
        arg_row_d = ArgW'(dig);
      end
      tcet_pkg::OP_ROW_DIGIT: begin
        arg_row_d = add_digit(arg_row_q, dig);
      end
      tcet_pkg::OP_COL_ZERO: begin
        arg_col_d = '0;
      end
      tcet_pkg::OP_COL_DIGIT: begin
        arg_col_d = add_digit(arg_col_q, dig);
      end
      tcet_pkg::OP_HOME: begin
        lin_d = '0;
        col_d = '0;
        tph_d = '0;
      end
      tcet_pkg::OP_POS_START: begin
        ecol_d = pos_col;
      end
      tcet_pkg::OP_POS_SET: begin
        lin_d = tgt_pos;
        div_d = tgt_pos;
      end
      tcet_pkg::OP_DIV_COL: begin
        if (status_o.lt_cols) begin
          col_d = ColW'(div_q);
        end else begin
          div_d = div_q - PosW'(Cols);
        end
      end
      tcet_pkg::OP_DIV_TAB: begin
        if (status_o.lt_tab) begin
          tph_d = TphW'(div_q);
        end else begin
          div_d = div_q - PosW'(TabW);
        end
      end
      tcet_pkg::OP_SCR_READ: begin
        mem_re = 1'b1;
        sw_d   = sw_q;
      end
      tcet_pkg::OP_SCR_MOVE: begin
        mem_we    = 1'b1;
        mem_wdata = rd_q;
        mem_re    = !status_o.move_last;
        mem_raddr = sw_q + PosW'(Cols + 1);
        sw_d      = sw_q + PosW'(1);
      end
      tcet_pkg::OP_FILL: begin
        mem_we = 1'b1;
        sw_d   = status_o.fill_last ? '0 : sw_q + PosW'(1);
      end
      tcet_pkg::OP_INIT_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = {tcet_pkg::RESET_ATTR, tcet_pkg::CH_SPACE};
        sw_d      = status_o.fill_last ? '0 : sw_q + PosW'(1);
      end
      tcet_pkg::OP_DONE: begin
        if (!mode_q && eos_q) begin
          shown_d = lin_q;
        end
        out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_q       <= '0;
      col_q       <= '0;
      tph_q       <= '0;
      shown_q     <= '0;
      arg_row_q   <= '0;
      arg_col_q   <= '0;
      attr_q      <= tcet_pkg::RESET_ATTR;
      sw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      lin_q       <= lin_d;
      col_q       <= col_d;
      tph_q       <= tph_d;
      shown_q     <= shown_d;
      arg_row_q   <= arg_row_d;
      arg_col_q   <= arg_col_d;
      sw_q        <= sw_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        attr_q <= normal_attr_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    div_q  <= div_d;
    ecol_q <= ecol_d;
    if (cmd_i.op == tcet_pkg::OP_POS_START) begin
      prod_q <= prod_d;
    end
    if (cmd_i.op == tcet_pkg::OP_LATCH) begin
      mode_q <= mode_i;
      char_q <= char_code_i[CharW-1:0];
      eos_q  <= end_of_string_i;
      idx_q  <= read_index_i;
      cell_q <= '0;
    end else if (cmd_i.op == tcet_pkg::OP_CAPTURE) begin
      cell_q <= rd_q;
    end
    if (cmd_i.op == tcet_pkg::OP_DONE) begin
      out_cursor_q <= IdxW'(shown_d);
      out_cell_q   <= cell_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      scr_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= scr_mem[mem_raddr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cursor_index_o = out_cursor_q;
  assign cell_char_o    = out_cell_q[CharW-1:0];
  assign cell_attr_o    = out_cell_q[CellW-1:CharW];

`ifndef NO_ASSERTIONS
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.op == tcet_pkg::OP_DONE))
    else $error("result raised without done command");

  a_move_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == tcet_pkg::OP_SCR_MOVE |-> sw_q < PosW'(LastLn))
    else $error("scroll move beyond last line");

  a_tab_div_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == tcet_pkg::OP_DIV_TAB |-> div_q < PosW'(Cols))
    else $error("tab phase derived from a value past the row width");
`endif

endmodule

[tb/tb_text_console_escape_terminal.sv]
`timescale 1ns / 1ps
// Testbench for text_console_escape_terminal: console bytes, escape sequences and cell reads
// are checked against a screen predictor kept in the bench, under random idling on both sides.
// Depends on tcet_pkg and the text_console_escape_terminal RTL.
module tb_text_console_escape_terminal;
  import tcet_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]  cursor;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
  } term_reply_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic                mode_i          = 1'b0;
  logic [7:0]          char_code_i     = '0;
  logic                end_of_string_i = 1'b0;
  logic [IDX_W-1:0]    read_index_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic [IDX_W-1:0]    cursor_index_o;
  logic [CHAR_W-1:0]   cell_char_o;
  logic [ATTR_W-1:0]   cell_attr_o;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [ATTR_W-1:0]   normal_attr_i   = '0;

  // screen predictor state
  logic [CELL_W-1:0]   screen_q [CELL_COUNT];
  logic [ATTR_W-1:0]   attr_q;
  int                  wpos;
  int                  shown_q;
  int                  row_q;
  int                  col_q;
  esc_e                esc_q;

  term_reply_t         awaited_replies [$];
  int                  mismatch_count = 0;
  bit                  gaps_on        = 1'b1;
  int                  hold_off_req   = 0;

  text_console_escape_terminal dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .char_code_i     (char_code_i),
    .end_of_string_i (end_of_string_i),
    .read_index_i    (read_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cursor_index_o  (cursor_index_o),
    .cell_char_o     (cell_char_o),
    .cell_attr_o     (cell_attr_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .normal_attr_i   (normal_attr_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #250ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void clear_screen();
    for (int i = 0; i < CELL_COUNT; i++) screen_q[i] = {attr_q, CH_SPACE};
    wpos = 0;
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < LAST_LINE; i++) screen_q[i] = screen_q[i + SCREEN_COLS];
    for (int i = LAST_LINE; i < CELL_COUNT; i++) screen_q[i] = {attr_q, CH_SPACE};
  endfunction

  function automatic int add_digit(int value, logic [CHAR_W-1:0] c);
    int n;
    n = value * 10 + (int'(c) - int'(CH_ZERO));
    return (n > int'(ARG_MAX)) ? int'(ARG_MAX) : n;
  endfunction

  function automatic void apply_final(int row, int col, logic [CHAR_W-1:0] c);
    int tgt;
    if (c == CH_UP_J) begin
      clear_screen();
    end else if (c == CH_UP_H) begin
      tgt = (row - 1) * SCREEN_COLS + (col - 1);
      if (tgt < 0) wpos = 0;
      else if (tgt >= CELL_COUNT) wpos = LAST_LINE;
      else wpos = tgt;
    end
  endfunction

  function automatic void escape_byte(logic [CHAR_W-1:0] c);
    logic digit;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    case (esc_q)
      ESC_SEEN: begin
        esc_q = (c == CH_LBR) ? ESC_BRACKET : ESC_IDLE;
      end
      ESC_BRACKET: begin
        if (digit) begin
          row_q = int'(c) - int'(CH_ZERO);
          esc_q = ESC_ROW;
        end else begin
          apply_final(1, 1, c);
          esc_q = ESC_IDLE;
        end
      end
      ESC_ROW: begin
        if (digit) begin
          row_q = add_digit(row_q, c);
        end else if (c == CH_SEMI) begin
          col_q = 0;
          esc_q = ESC_COL;
        end else begin
          apply_final(row_q, 1, c);
          esc_q = ESC_IDLE;
        end
      end
      ESC_COL: begin
        if (digit) begin
          col_q = add_digit(col_q, c);
        end else begin
          apply_final(row_q, col_q, c);
          esc_q = ESC_IDLE;
        end
      end
      default: begin
        esc_q = ESC_IDLE;
      end
    endcase
  endfunction

  function automatic void feed_console_byte(logic [CHAR_W-1:0] c);
    if (esc_q != ESC_IDLE) begin
      escape_byte(c);
    end else if (c >= CH_SPACE && c <= CH_TILDE) begin
      screen_q[wpos] = {attr_q, c};
      wpos++;
      if (wpos >= CELL_COUNT) begin
        scroll_screen();
        wpos = LAST_LINE;
      end
    end else if (c == CH_NL) begin
      if (wpos + SCREEN_COLS >= CELL_COUNT) begin
        scroll_screen();
        wpos = LAST_LINE;
      end else begin
        wpos += SCREEN_COLS - (wpos % SCREEN_COLS);
      end
    end else if (c == CH_CR) begin
      wpos -= wpos % SCREEN_COLS;
    end else if (c == CH_BS) begin
      if (wpos > 0) wpos--;
    end else if (c == CH_TAB) begin
      wpos += TAB_WIDTH - ((wpos % SCREEN_COLS) % TAB_WIDTH);
      if (wpos >= CELL_COUNT) begin
        scroll_screen();
        wpos = LAST_LINE;
      end
    end else if (c == CH_ESC) begin
      esc_q = ESC_SEEN;
    end
  endfunction

  function automatic term_reply_t compute_terminal_reply(logic mode, logic [7:0] code,
                                                         logic eos, logic [IDX_W-1:0] idx);
    term_reply_t r;
    r = '0;
    if (!mode) begin
      feed_console_byte(code[CHAR_W-1:0]);
      if (eos) shown_q = wpos;
    end else if (idx < CELL_COUNT) begin
      r.ch   = screen_q[idx][CHAR_W-1:0];
      r.attr = screen_q[idx][CELL_W-1:CHAR_W];
    end
    r.cursor = IDX_W'(shown_q);
    return r;
  endfunction

  function automatic int gap_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 60) : $urandom_range(1, 3);
  endfunction

  function automatic void flag_mismatch(string what, int expv, int gotv);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, expv, gotv);
  endfunction

  always @(posedge clk_i) begin : reply_check
    term_reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_replies.size() == 0) begin
        flag_mismatch("unrequested reply, cursor_index", -1, cursor_index_o);
      end else begin
        want = awaited_replies.pop_front();
        if (cursor_index_o !== want.cursor)
          flag_mismatch("cursor_index", want.cursor, cursor_index_o);
        if (cell_char_o !== want.ch) flag_mismatch("cell_char", want.ch, cell_char_o);
        if (cell_attr_o !== want.attr) flag_mismatch("cell_attr", want.attr, cell_attr_o);
      end
    end
  end

  // receiver: random stalls, plus a counted hold-off on request
  initial begin : reply_drain
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_off_req > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_off_req) @(posedge clk_i);
        hold_off_req = 0;
      end else if (!gaps_on || $urandom_range(0, 3) != 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        n = gap_length();
        repeat (n) @(posedge clk_i);
      end
    end
  end

  task automatic send_request(input logic mode, input logic [7:0] code, input logic eos,
                              input logic [IDX_W-1:0] idx);
    int gap;
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      gap = gap_length();
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    mode_i          <= mode;
    char_code_i     <= code;
    end_of_string_i <= eos;
    read_index_i    <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    awaited_replies.push_back(compute_terminal_reply(mode, code, eos, idx));
  endtask

  task automatic send_char(input logic [7:0] code, input logic eos);
    send_request(1'b0, code, eos, IDX_W'($urandom));
  endtask

  task automatic finish_phase();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_replies.size() != 0);
  endtask

  task automatic write_normal_attr(input logic [ATTR_W-1:0] value);
    while (!in_ready_o) @(posedge clk_i);
    cfg_valid_i   <= 1'b1;
    normal_attr_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    attr_q = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_printables_and_controls();
    send_char(8'hC1, 1'b0);
    send_char({1'b0, CH_TILDE}, 1'b0);
    send_char({1'b0, CH_SPACE}, 1'b1);
    send_char(8'h7F, 1'b0);
    send_char(8'h00, 1'b1);
    send_char({1'b0, CH_CR}, 1'b0);
    send_char({1'b1, CH_BS}, 1'b1);
    send_char({1'b0, CH_TAB}, 1'b1);
    send_char({1'b0, CH_NL}, 1'b1);
  endtask

  task automatic test_cell_reads();
    send_request(1'b1, 8'hFF, 1'b1, IDX_W'(0));
    send_request(1'b1, 8'h00, 1'b0, IDX_W'(1));
    send_request(1'b1, 8'h00, 1'b1, IDX_W'(CELL_COUNT - 1));
    send_request(1'b1, 8'h5A, 1'b0, {IDX_W{1'b1}});
  endtask

  task automatic test_escape_sequences();
    send_char({1'b0, CH_ESC}, 1'b0);
    send_char("x", 1'b1);
    send_char({1'b0, CH_ESC}, 1'b0);
    send_char({1'b0, CH_LBR}, 1'b0);
    send_char({1'b0, CH_SEMI}, 1'b1);
    send_char({1'b0, CH_ESC}, 1'b0);
    send_char({1'b0, CH_LBR}, 1'b0);
    send_char({1'b0, CH_ZERO}, 1'b0);
    send_char({1'b0, CH_UP_H}, 1'b1);
    send_char({1'b0, CH_ESC}, 1'b0);
    send_char({1'b0, CH_LBR}, 1'b0);
    send_char("5", 1'b0);
    send_char("0", 1'b0);
    send_char("0", 1'b0);
    send_char("0", 1'b0);
    send_char({1'b0, CH_UP_H}, 1'b1);
    send_char({1'b0, CH_ESC}, 1'b0);
    send_char({1'b0, CH_LBR}, 1'b0);
    send_char("3", 1'b0);
    send_char("X", 1'b1);
    send_char({1'b0, CH_ESC}, 1'b0);
    send_char({1'b0, CH_LBR}, 1'b0);
    send_char({1'b0, CH_UP_J}, 1'b1);
    send_request(1'b1, 8'h00, 1'b0, IDX_W'(0));
  endtask

  task automatic test_backpressure();
    gaps_on      = 1'b0;
    hold_off_req = 200;
    repeat (16) send_char({1'b0, 7'($urandom_range(32, 126))}, 1'($urandom));
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic(input int item_target);
    logic [7:0] burst [$];
    int         sent;
    int         kind;
    int         n;
    int         r;
    sent = 0;
    while (sent < item_target) begin
      burst.delete();
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 79) == 0) gaps_on = !gaps_on;
      if (kind < 20) begin
        send_request(1'b1, 8'($urandom), 1'($urandom),
                     ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(CELL_COUNT, 2047))
                                                 : IDX_W'($urandom_range(0, CELL_COUNT - 1)));
        sent++;
      end else begin
        if (kind < 55) begin
          n = $urandom_range(1, 12);
          repeat (n) burst.push_back({1'($urandom), 7'($urandom_range(32, 126))});
        end else if (kind < 70) begin
          case ($urandom_range(0, 3))
            0:       burst.push_back({1'($urandom), CH_NL});
            1:       burst.push_back({1'($urandom), CH_CR});
            2:       burst.push_back({1'($urandom), CH_BS});
            default: burst.push_back({1'($urandom), CH_TAB});
          endcase
        end else if (kind < 90) begin
          burst.push_back({1'($urandom), CH_ESC});
          if ($urandom_range(0, 9) == 0) begin
            burst.push_back(8'($urandom));
          end else begin
            burst.push_back({1'($urandom), CH_LBR});
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 5) : $urandom_range(0, 2);
            repeat (n) burst.push_back({1'b0, 7'(int'(CH_ZERO) + $urandom_range(0, 9))});
            if (n > 0 && $urandom_range(0, 2) != 0) begin
              burst.push_back({1'($urandom), CH_SEMI});
              n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 5) : $urandom_range(0, 2);
              repeat (n) burst.push_back({1'b0, 7'(int'(CH_ZERO) + $urandom_range(0, 9))});
            end
            r = $urandom_range(0, 19);
            if (r == 0) burst.push_back({1'($urandom), CH_UP_J});
            else if (r < 15) burst.push_back({1'($urandom), CH_UP_H});
            else burst.push_back(8'($urandom));
          end
        end else begin
          n = $urandom_range(1, 3);
          repeat (n) burst.push_back(8'($urandom));
        end
        sent += burst.size();
        foreach (burst[i])
          send_char(burst[i], (i == burst.size() - 1) ? 1'($urandom_range(0, 1))
                                                      : ($urandom_range(0, 7) == 0));
      end
    end
  endtask

  initial begin
    attr_q  = RESET_ATTR;
    shown_q = 0;
    row_q   = 0;
    col_q   = 0;
    esc_q   = ESC_IDLE;
    clear_screen();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_printables_and_controls();
    test_cell_reads();
    test_escape_sequences();
    finish_phase();

    write_normal_attr(8'hFF);
    test_random_traffic(700);
    test_backpressure();
    finish_phase();

    write_normal_attr(8'h00);
    test_random_traffic(700);
    finish_phase();

    write_normal_attr(8'($urandom_range(1, 254)));
    test_random_traffic(600);
    finish_phase();

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tcet_pkg.sv
rtl/tcet_ctrl.sv
rtl/tcet_dp.sv
rtl/text_console_escape_terminal.sv
tb/tb_text_console_escape_terminal.sv
